// ===== rtl/gpbc_pkg.sv =====
// ----------------------------------------------------------------------------
// gpbc_pkg
// Shared types and codes for the pinned block cache directory.
// ----------------------------------------------------------------------------
package gpbc_pkg;

   localparam int SLOTS  = 64;
   localparam int ID_W   = 31;
   localparam int SLOT_W = 6;
   localparam int OP_W   = 2;

   localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_ACCESS  = 2'd2;

   localparam logic [1:0] ST_EMPTY   = 2'd0;
   localparam logic [1:0] ST_LOADING = 2'd1;
   localparam logic [1:0] ST_LOADED  = 2'd2;

   typedef enum logic [1:0] {
      CLS_REQ = 2'd0,
      CLS_REL = 2'd1,
      CLS_ACC = 2'd2,
      CLS_BAD = 2'd3
   } cls_type;

   typedef struct packed {
      cls_type             cls;
      logic [ID_W-1:0]     blk_num;
      logic [SLOT_W-1:0]   slot;
   } item_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot_out;
      logic                hit;
      logic                evicted;
      logic [ID_W-1:0]     other_blk_num;
      logic                fill_needed;
      logic                fail;
   } rsp_type;

endpackage

// ===== rtl/gclock_pinned_block_cache.sv =====
// Release and access read then update the named slot; op 3 or a bad slot fails.
// Request: scan slots from 0 to a hit; a miss fills the hand slot if any are free,
// fails if all are pinned, else sweeps from the hand through the victim.
// The back end takes one word at a time through the single-port slot memory;
// result stalls hold the back end.
// Reset: synchronous; directory empty at once via per-slot valid bits, hand zero.
// ----------------------------------------------------------------------------
// gclock_pinned_block_cache
// Fully associative slot directory with generalized-clock replacement.
// ----------------------------------------------------------------------------
module gclock_pinned_block_cache
   import gpbc_pkg::*;
#(
   parameter int COUNT_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [OP_W-1:0]   req_op,
   input  logic [ID_W-1:0]   req_blk_num,
   input  logic [SLOT_W-1:0] req_slot,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [SLOT_W-1:0] rsp_slot_out,
   output logic              rsp_hit,
   output logic              rsp_evicted,
   output logic [ID_W-1:0]   rsp_other_blk_num,
   output logic              rsp_fill_needed,
   output logic              rsp_fail
);

   logic     q_valid, q_pop;
   item_type q_item;
   logic     res_valid, res_ready;
   rsp_type  res;
   rsp_type  out_ff;
   logic     out_valid_ff, out_valid_in;

   gpbc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .full     (req_full),
      .op       (req_op),
      .blk_num  (req_blk_num),
      .slot     (req_slot),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   gpbc_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   assign res_ready = !out_valid_ff || rsp_pop;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_ff <= res;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_slot_out      = out_ff.slot_out;
   assign rsp_hit           = out_ff.hit;
   assign rsp_evicted       = out_ff.evicted;
   assign rsp_other_blk_num = out_ff.other_blk_num;
   assign rsp_fill_needed   = out_ff.fill_needed;
   assign rsp_fail          = out_ff.fail;

endmodule

// ===== rtl/gpbc_front.sv =====
// ----------------------------------------------------------------------------
// gpbc_front
// Input queue: classifies each word and holds up to two for the back end.
// ----------------------------------------------------------------------------
module gpbc_front
   import gpbc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [OP_W-1:0]   op,
   input  logic [ID_W-1:0]   blk_num,
   input  logic [SLOT_W-1:0] slot,
   output logic              q_valid,
   output item_type          q_item,
   input  logic              q_pop
);

   item_type   buf_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   item_new;
   logic       do_push, do_pop;

   always_comb begin
      item_new.blk_num = blk_num;
      item_new.slot    = slot;
      if (op == OP_REQUEST) begin
         item_new.cls = CLS_REQ;
      end else if (32'(slot) >= 32'(SLOTS)) begin
         item_new.cls = CLS_BAD;
      end else if (op == OP_RELEASE) begin
         item_new.cls = CLS_REL;
      end else if (op == OP_ACCESS) begin
         item_new.cls = CLS_ACC;
      end else begin
         item_new.cls = CLS_BAD;
      end
   end

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = buf_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         buf_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

// ===== rtl/gpbc_back.sv =====
// ----------------------------------------------------------------------------
// gpbc_back
// Directory engine: slot memory, lookup scan, clock sweep, release, access.
// ----------------------------------------------------------------------------
module gpbc_back
   import gpbc_pkg::*;
#(
   parameter int COUNT_BITS = 8
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  item_type q_item,
   output logic     q_pop,
   output logic     res_valid,
   output rsp_type  res,
   input  logic     res_ready
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   typedef struct packed {
      logic [ID_W-1:0]       block;
      logic [COUNT_BITS-1:0] pin;
      logic [COUNT_BITS-1:0] refc;
      logic [1:0]            status;
   } entry_type;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_LOOK_RD  = 8'b0000_0010,
      S_LOOK_EV  = 8'b0000_0100,
      S_SWEEP_RD = 8'b0000_1000,
      S_SWEEP_EV = 8'b0001_0000,
      S_SLOT_RD  = 8'b0010_0000,
      S_SLOT_EV  = 8'b0100_0000,
      S_FAIL     = 8'b1000_0000
   } state_type;

   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
   localparam logic [IW-1:0]         LAST    = IW'(SLOTS - 1);

   entry_type          mem [SLOTS];
   logic [SLOTS-1:0]   valid_ff;
   entry_type          rdata_ff;
   logic               rvalid_ff;
   state_type          state_ff, state_in;
   item_type           item_ff, item_in;
   logic [IW-1:0]      cnt_ff, cnt_in;
   logic [IW-1:0]      hand_ff, hand_in;
   logic [CW-1:0]      free_ff, free_in;
   logic [CW-1:0]      pinned_ff, pinned_in;
   logic               rd_en, wr_en;
   logic [IW-1:0]      rd_addr, wr_addr;
   entry_type          wr_data, ent, fresh;
   logic [IW-1:0]      cnt_next, slot_idx;
   logic [COUNT_BITS-1:0] nref;

   assign cnt_next = (cnt_ff == LAST) ? '0 : cnt_ff + IW'(1);
   assign slot_idx = IW'(item_ff.slot);

   always_comb begin
      ent = rdata_ff;
      if (!rvalid_ff) begin
         ent.pin    = '0;
         ent.refc   = '0;
         ent.status = ST_EMPTY;
      end
      fresh.block  = item_ff.blk_num;
      fresh.pin    = CNT_ONE;
      fresh.refc   = CNT_ONE;
      fresh.status = ST_LOADING;
      nref = (ent.refc != '0) ? ent.refc - CNT_ONE : ent.refc;
   end

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      cnt_in    = cnt_ff;
      hand_in   = hand_ff;
      free_in   = free_ff;
      pinned_in = pinned_ff;
      q_pop     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = cnt_ff;
      wr_en     = 1'b0;
      wr_addr   = cnt_ff;
      wr_data   = ent;
      res_valid = 1'b0;
      res       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               cnt_in  = '0;
               case (q_item.cls)
                  CLS_REQ:          state_in = S_LOOK_RD;
                  CLS_REL, CLS_ACC: state_in = S_SLOT_RD;
                  default:          state_in = S_FAIL;
               endcase
            end
         end
         S_LOOK_RD: begin
            rd_en    = 1'b1;
            state_in = S_LOOK_EV;
         end
         S_LOOK_EV: begin
            if (ent.status != ST_EMPTY && ent.block == item_ff.blk_num) begin
               res_valid    = 1'b1;
               res.slot_out = SLOT_W'(cnt_ff);
               res.hit      = 1'b1;
               if (res_ready) begin
                  wr_en        = 1'b1;
                  wr_data.pin  = (ent.pin == '1) ? ent.pin : ent.pin + CNT_ONE;
                  wr_data.refc = (ent.refc == '1) ? ent.refc : ent.refc + CNT_ONE;
                  if (ent.pin == '0) begin
                     pinned_in = pinned_ff + CW'(1);
                  end
                  state_in = S_IDLE;
               end
            end else if (cnt_ff != LAST) begin
               cnt_in   = cnt_next;
               state_in = S_LOOK_RD;
            end else if (free_ff != '0) begin
               res_valid    = 1'b1;
               res.slot_out = SLOT_W'(hand_ff);
               if (res_ready) begin
                  wr_en     = 1'b1;
                  wr_addr   = hand_ff;
                  wr_data   = fresh;
                  free_in   = free_ff - CW'(1);
                  pinned_in = pinned_ff + CW'(1);
                  hand_in   = (hand_ff == LAST) ? '0 : hand_ff + IW'(1);
                  state_in  = S_IDLE;
               end
            end else if (pinned_ff == CW'(SLOTS)) begin
               state_in = S_FAIL;
            end else begin
               cnt_in   = hand_ff;
               state_in = S_SWEEP_RD;
            end
         end
         S_SWEEP_RD: begin
            rd_en    = 1'b1;
            state_in = S_SWEEP_EV;
         end
         S_SWEEP_EV: begin
            if (ent.pin != '0) begin
               cnt_in   = cnt_next;
               state_in = S_SWEEP_RD;
            end else if (nref != '0) begin
               wr_en        = 1'b1;
               wr_data.refc = nref;
               cnt_in       = cnt_next;
               state_in     = S_SWEEP_RD;
            end else begin
               res_valid    = 1'b1;
               res.slot_out = SLOT_W'(cnt_ff);
               if (ent.status != ST_EMPTY) begin
                  res.evicted       = 1'b1;
                  res.other_blk_num = ent.block;
               end
               if (res_ready) begin
                  wr_en     = 1'b1;
                  wr_data   = fresh;
                  pinned_in = pinned_ff + CW'(1);
                  if (ent.status == ST_EMPTY && free_ff != '0) begin
                     free_in = free_ff - CW'(1);
                  end
                  hand_in  = cnt_next;
                  state_in = S_IDLE;
               end
            end
         end
         S_SLOT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = slot_idx;
            state_in = S_SLOT_EV;
         end
         S_SLOT_EV: begin
            res_valid    = 1'b1;
            res.slot_out = item_ff.slot;
            wr_addr      = slot_idx;
            if (item_ff.cls == CLS_REL) begin
               if (ent.pin == '0) begin
                  res.fail = 1'b1;
               end else if (res_ready) begin
                  wr_en       = 1'b1;
                  wr_data.pin = ent.pin - CNT_ONE;
                  if (ent.pin == CNT_ONE) begin
                     pinned_in = pinned_ff - CW'(1);
                  end
               end
            end else begin
               if (ent.status == ST_EMPTY || ent.block != item_ff.blk_num) begin
                  res.fail = 1'b1;
               end else begin
                  res.other_blk_num = item_ff.blk_num;
                  if (ent.status == ST_LOADING) begin
                     res.fill_needed = 1'b1;
                     if (res_ready) begin
                        wr_en          = 1'b1;
                        wr_data.status = ST_LOADED;
                     end
                  end
               end
            end
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         S_FAIL: begin
            res_valid = 1'b1;
            res.fail  = 1'b1;
            if (item_ff.cls != CLS_REQ) begin
               res.slot_out = item_ff.slot;
            end
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         hand_ff   <= '0;
         free_ff   <= CW'(SLOTS);
         pinned_ff <= '0;
         valid_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         hand_ff   <= hand_in;
         free_ff   <= free_in;
         pinned_ff <= pinned_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      cnt_ff  <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff  <= mem[rd_addr];
         rvalid_ff <= valid_ff[rd_addr];
      end
   end

`ifndef SYNTHESIS
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      free_ff <= CW'(SLOTS)) else $error("free count out of range");
   a_pinned_range: assert property (@(posedge clock) disable iff (reset)
      pinned_ff <= CW'(SLOTS)) else $error("pinned count out of range");
   a_wr_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_LOOK_EV || state_ff == S_SWEEP_EV ||
                 state_ff == S_SLOT_EV)) else $error("write outside eval");
   a_res_excl: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !(res.hit && (res.evicted || res.fail)))
      else $error("conflicting result flags");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != S_IDLE) else $error("popped word not taken");
`endif

endmodule
